// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the vertex normal accumulator.
// Depends on: a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vna_pkg.sv =====
// Package for the vertex normal accumulator: word types, op codes, constants.
// Depends on: nothing.
package vna_pkg;

    // Fixed field widths of the input and result words
    localparam int IDX_BITS    = 10;
    localparam int FIELD_COORD = 16;
    localparam int FIELD_NRM   = 48;

    // Parameter defaults
    localparam int DEF_VERTEX_COUNT = 1024;
    localparam int DEF_COORD_BITS   = 16;
    localparam int DEF_ACC_BITS     = 48;

    // Command queue between front and back (power of two)
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

    // Action codes of an input word
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_TRIANGLE = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;

    typedef struct packed {
        logic [1:0]                    action;
        logic [IDX_BITS-1:0]           vertex_index;
        logic signed [FIELD_COORD-1:0] pos_x;
        logic signed [FIELD_COORD-1:0] pos_y;
        logic signed [FIELD_COORD-1:0] pos_z;
        logic [IDX_BITS-1:0]           corner_a;
        logic [IDX_BITS-1:0]           corner_b;
        logic [IDX_BITS-1:0]           corner_c;
    } vna_in_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]           read_index;
        logic signed [FIELD_NRM-1:0]   normal_x;
        logic signed [FIELD_NRM-1:0]   normal_y;
        logic signed [FIELD_NRM-1:0]   normal_z;
        logic signed [FIELD_COORD-1:0] out_x;
        logic signed [FIELD_COORD-1:0] out_y;
        logic signed [FIELD_COORD-1:0] out_z;
    } vna_out_t;

    // Classified work for the back end
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRIANGLE,
        OP_READ,
        OP_READ_BLANK
    } vna_op_t;

    typedef struct packed {
        vna_op_t op;
        vna_in_t word;
    } vna_cmd_t;

endpackage

// ===== rtl/core/vna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/vna_cmd_queue.sv =====
// Short command queue between the front and back of the normal accumulator.
// Depends on: vna_pkg.
module vna_cmd_queue
    import vna_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  vna_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output vna_cmd_t head,
    output logic     not_empty
);

    vna_cmd_t                  store [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;

    assign full      = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store[rd_ptr_reg];

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers; they wrap on their own since the depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/vna_front.sv =====
// Front end: takes input words, checks indices, classifies them into commands.
// Depends on: vna_pkg.
module vna_front
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = DEF_VERTEX_COUNT
) (
    input  logic     item_valid,
    output logic     item_ready,
    input  vna_in_t  item,
    input  logic     queue_full,
    input  logic     clearing,
    output logic     push,
    output vna_cmd_t push_cmd
);

    logic idx_ok;
    logic a_ok;
    logic b_ok;
    logic c_ok;
    logic keep;

    // Range checks against the vertex count
    assign idx_ok = (32'(item.vertex_index) < 32'(VERTEX_COUNT));
    assign a_ok   = (32'(item.corner_a) < 32'(VERTEX_COUNT));
    assign b_ok   = (32'(item.corner_b) < 32'(VERTEX_COUNT));
    assign c_ok   = (32'(item.corner_c) < 32'(VERTEX_COUNT));

    // Hold off while the queue is full or the normal store is being cleared
    assign item_ready = !queue_full && !clearing;

    // Classify; drop out-of-range loads and triangles and the unused action
    always_comb
    begin
        keep             = 1'b0;
        push_cmd.word    = item;
        push_cmd.op      = OP_READ_BLANK;
        case (item.action)
            ACT_LOAD:
            begin
                keep        = idx_ok;
                push_cmd.op = OP_LOAD;
            end
            ACT_TRIANGLE:
            begin
                keep        = a_ok && b_ok && c_ok;
                push_cmd.op = OP_TRIANGLE;
            end
            ACT_READ:
            begin
                keep = 1'b1;
                if (idx_ok)
                begin
                    push_cmd.op = OP_READ;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = item_valid && item_ready && keep;

endmodule

// ===== rtl/core/vna_back.sv =====
// Back end: runs commands against the position and normal memories.
// Depends on: vna_pkg, vna_ram.
module vna_back
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
    parameter int COORD_BITS   = DEF_COORD_BITS,
    parameter int ACC_BITS     = DEF_ACC_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  vna_cmd_t cmd,
    input  logic     cmd_valid,
    output logic     cmd_pop,
    output logic     clearing,
    output logic     result_valid,
    input  logic     result_ready,
    output vna_out_t result
);

    localparam int AW   = $clog2(VERTEX_COUNT);
    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 1;
    localparam int PW   = 2 * EW;
    localparam int NW   = PW + 1;
    localparam int SW   = ((ACC_BITS > NW) ? ACC_BITS : NW) + 1;
    localparam int POSW = 3 * CB;
    localparam int NRMW = 3 * ACC_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_TRI_B,
        S_TRI_C,
        S_TRI_E,
        S_TRI_M,
        S_TRI_N,
        S_ACC_RD,
        S_ACC_WR
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_BITS-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[AW-1:0];
    endfunction

    // Low COORD_BITS of the zero-extended field; the top bit is the sign
    function automatic logic [CB-1:0] to_coord(input logic [FIELD_COORD-1:0] f);
        logic [63:0] w;
        w = {48'd0, f};
        return w[CB-1:0];
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_acc(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [NW-1:0]       n
    );
        logic signed [SW-1:0] s;
        logic                 fits;
        s    = SW'(a) + SW'(n);
        fits = (s[SW-1:ACC_BITS-1] == '0) || (s[SW-1:ACC_BITS-1] == '1);
        if (fits)
        begin
            return s[ACC_BITS-1:0];
        end
        else if (s[SW-1])
        begin
            return {1'b1, {(ACC_BITS-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(ACC_BITS-1){1'b1}}};
        end
    endfunction

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [1:0]      sel_reg, sel_next;
    logic            result_valid_reg, result_valid_next;
    vna_out_t        result_reg, result_next;
    vna_cmd_t        cmd_reg;

    logic signed [CB-1:0] v0_reg [3];
    logic signed [CB-1:0] v1_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] p_reg  [6];
    logic signed [NW-1:0] n_reg  [3];

    logic                  pos_we, pos_re;
    logic [AW-1:0]         pos_waddr, pos_raddr;
    logic [POSW-1:0]       pos_wdata, pos_rdata;
    logic                  nrm_we, nrm_re;
    logic [AW-1:0]         nrm_waddr, nrm_raddr;
    logic [NRMW-1:0]       nrm_wdata, nrm_rdata, nrm_sat;
    logic signed [CB-1:0]       rd_pos [3];
    logic signed [ACC_BITS-1:0] rd_nrm [3];
    logic [AW-1:0]         corner_addr;
    logic                  out_free;

    vna_ram #(.WIDTH(POSW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(NRMW), .DEPTH(VERTEX_COUNT)) u_nrm_ram (
        .clk   (clk),
        .we    (nrm_we),
        .waddr (nrm_waddr),
        .wdata (nrm_wdata),
        .re    (nrm_re),
        .raddr (nrm_raddr),
        .rdata (nrm_rdata)
    );

    // Split memory words into x, y, z and saturate the accumulated sums
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rd_pos[k] = pos_rdata[k*CB +: CB];
            rd_nrm[k] = nrm_rdata[k*ACC_BITS +: ACC_BITS];
            nrm_sat[k*ACC_BITS +: ACC_BITS] = sat_acc(rd_nrm[k], n_reg[k]);
        end
    end

    // Pick the corner for the current read-modify-write
    always_comb
    begin
        case (sel_reg)
            2'd0:    corner_addr = to_addr(cmd_reg.word.corner_a);
            2'd1:    corner_addr = to_addr(cmd_reg.word.corner_b);
            default: corner_addr = to_addr(cmd_reg.word.corner_c);
        endcase
    end

    assign out_free     = !result_valid_reg || result_ready;
    assign clearing     = (state_reg == S_CLEAR);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Sequence memory accesses and result loads
    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        sel_next          = sel_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        cmd_pop           = 1'b0;
        pos_we            = 1'b0;
        pos_re            = 1'b0;
        pos_waddr         = to_addr(cmd.word.vertex_index);
        pos_raddr         = to_addr(cmd.word.vertex_index);
        pos_wdata         = {to_coord(cmd.word.pos_z), to_coord(cmd.word.pos_y),
                             to_coord(cmd.word.pos_x)};
        nrm_we            = 1'b0;
        nrm_re            = 1'b0;
        nrm_waddr         = to_addr(cmd.word.vertex_index);
        nrm_raddr         = to_addr(cmd.word.vertex_index);
        nrm_wdata         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                nrm_we    = 1'b1;
                nrm_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            pos_we  = 1'b1;
                            nrm_we  = 1'b1;
                        end
                        OP_TRIANGLE:
                        begin
                            cmd_pop    = 1'b1;
                            pos_re     = 1'b1;
                            pos_raddr  = to_addr(cmd.word.corner_a);
                            state_next = S_TRI_B;
                        end
                        OP_READ:
                        begin
                            cmd_pop    = 1'b1;
                            pos_re     = 1'b1;
                            nrm_re     = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop                = 1'b1;
                                result_valid_next      = 1'b1;
                                result_next            = '0;
                                result_next.read_index = cmd.word.vertex_index;
                            end
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (out_free)
                begin
                    result_valid_next      = 1'b1;
                    result_next.read_index = cmd_reg.word.vertex_index;
                    result_next.normal_x   = FIELD_NRM'(rd_nrm[0]);
                    result_next.normal_y   = FIELD_NRM'(rd_nrm[1]);
                    result_next.normal_z   = FIELD_NRM'(rd_nrm[2]);
                    result_next.out_x      = FIELD_COORD'(rd_pos[0]);
                    result_next.out_y      = FIELD_COORD'(rd_pos[1]);
                    result_next.out_z      = FIELD_COORD'(rd_pos[2]);
                    state_next             = S_IDLE;
                end
            end
            S_TRI_B:
            begin
                pos_re     = 1'b1;
                pos_raddr  = to_addr(cmd_reg.word.corner_b);
                state_next = S_TRI_C;
            end
            S_TRI_C:
            begin
                pos_re     = 1'b1;
                pos_raddr  = to_addr(cmd_reg.word.corner_c);
                state_next = S_TRI_E;
            end
            S_TRI_E:
            begin
                state_next = S_TRI_M;
            end
            S_TRI_M:
            begin
                state_next = S_TRI_N;
            end
            S_TRI_N:
            begin
                sel_next   = 2'd0;
                state_next = S_ACC_RD;
            end
            S_ACC_RD:
            begin
                nrm_re     = 1'b1;
                nrm_raddr  = corner_addr;
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                nrm_we    = 1'b1;
                nrm_waddr = corner_addr;
                nrm_wdata = nrm_sat;
                if (sel_reg == 2'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_ACC_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            sel_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            sel_reg          <= sel_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // Face normal datapath: corners, edges, products, cross product
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_TRI_B)
        begin
            v0_reg <= rd_pos;
        end
        if (state_reg == S_TRI_C)
        begin
            v1_reg <= rd_pos;
        end
        if (state_reg == S_TRI_E)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= EW'(v1_reg[k]) - EW'(v0_reg[k]);
                e2_reg[k] <= EW'(rd_pos[k]) - EW'(v0_reg[k]);
            end
        end
        if (state_reg == S_TRI_M)
        begin
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
        end
        if (state_reg == S_TRI_N)
        begin
            n_reg[0] <= NW'(p_reg[0]) - NW'(p_reg[1]);
            n_reg[1] <= NW'(p_reg[2]) - NW'(p_reg[3]);
            n_reg[2] <= NW'(p_reg[4]) - NW'(p_reg[5]);
        end
    end

endmodule

// ===== rtl/core/vertex_normal_accumulator.sv =====
// Channel   Direction  Word       Handshake
// item      in         vna_in_t   item_valid / item_ready
// result    out        vna_out_t  result_valid / result_ready
//
// Back end per word: a load writes both memories at once; a read waits for the
// registered read data; a triangle makes three position reads on the single
// position read port, then one read-modify-write of the normal memory per corner.
// After reset the normal memory is cleared, one vertex a cycle, over all
// VERTEX_COUNT entries; item_ready stays low during that pass.
// A four-word command queue lets the input run ahead of the back end, and the
// result register lets the back end keep working while a result waits.
// Depends on: vna_pkg, vna_front, vna_cmd_queue, vna_back, assert_macros.svh.
`include "assert_macros.svh"

module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
    parameter int COORD_BITS   = DEF_COORD_BITS,
    parameter int ACC_BITS     = DEF_ACC_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  vna_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output vna_out_t result
);

    logic     queue_full;
    logic     queue_not_empty;
    logic     clearing;
    logic     push;
    logic     pop;
    vna_cmd_t push_cmd;
    vna_cmd_t head_cmd;

    vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    vna_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .head      (head_cmd),
        .not_empty (queue_not_empty)
    );

    vna_back #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_BITS   (COORD_BITS),
        .ACC_BITS     (ACC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .cmd_valid    (queue_not_empty),
        .cmd_pop      (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Queue is never overrun or underrun; the clearing pass runs once
    `ASSERT_SAME(a_no_push_full, push, !queue_full, "push into full queue")
    `ASSERT_SAME(a_no_pop_empty, pop, queue_not_empty, "pop from empty queue")
    `ASSERT_SAME(a_no_accept_clear, clearing, !item_ready && !pop, "activity during clear")
    `ASSERT_NEXT(a_clear_once, $fell(clearing), !clearing, "clearing pass restarted")

endmodule
